@@ hw/rtl/sbsh_pkg.sv @@
// ----------------------------------------------------------------------------
// Swept box segment hit test package
// Widths, register codes and pipeline sizes shared by the hit test RTL.
// ----------------------------------------------------------------------------
package sbsh_pkg;

  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned NUM_PAIRS  = NUM_AXES * (NUM_AXES - 1);
  localparam int unsigned NUM_STAGES = 6;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned IN_FIELDS  = 12;
  localparam int unsigned AXIS_IN_W  = IN_FIELDS * COORD_W;
  localparam int unsigned AXIS_OUT_W = 8;

  localparam int unsigned EXT_W      = 24;
  localparam int unsigned EPS_W      = 8;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = EXT_W;

  // Grown bounds and slab numerators fit 34 bits signed, deltas 33 bits.
  localparam int unsigned NUM_W      = 34;
  localparam int unsigned DEL_W      = 33;
  localparam int unsigned MAG_W      = 33;
  localparam int unsigned PROD_W     = 66;

  localparam logic [EPS_W-1:0] EPS_RESET = 8'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXTENT_X     = 8'd0,
    REG_EXTENT_Y     = 8'd1,
    REG_EXTENT_Z     = 8'd2,
    REG_SLAB_EPSILON = 8'd3
  } cfg_reg_e;

  typedef logic signed [NUM_W-1:0] slab_num_t;
  typedef logic [MAG_W-1:0]        slab_mag_t;

endpackage

@@ hw/rtl/swept_box_segment_hit_test.sv @@
// Throughput: one test per cycle while the output is not stalled; the six register stages each hold one item.
// A stalled output holds only the stages that are full, so bubbles are squeezed.
// Reset clears all stage valid bits, sets the extents to 0 and the epsilon to 8.
// ----------------------------------------------------------------------------
// Swept box segment hit test
// Slab test of a segment against an axis-aligned box grown by the hull
// extents and a margin, with exact rational compares by cross products.
// ----------------------------------------------------------------------------
module swept_box_segment_hit_test (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // start_x, start_y, start_z, end_x, end_y, end_z,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  logic [sbsh_pkg::AXIS_IN_W-1:0]  s_axis_tdata_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // hit, then zero padding
  output logic [sbsh_pkg::AXIS_OUT_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [sbsh_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sbsh_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import sbsh_pkg::*;

  // Configuration registers
  logic [EXT_W-1:0] ext_q [NUM_AXES];
  logic [EPS_W-1:0] eps_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        ext_q[a] <= '0;
      end
      eps_q <= EPS_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_EXTENT_X:     ext_q[0] <= cfg_data_i;
        REG_EXTENT_Y:     ext_q[1] <= cfg_data_i;
        REG_EXTENT_Z:     ext_q[2] <= cfg_data_i;
        REG_SLAB_EPSILON: eps_q    <= cfg_data_i[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage loads when it is empty or the next one moves.
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] stage_en;

  always_comb begin
    stage_en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || m_axis_tready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  assign s_axis_tready_o = stage_en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (stage_en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Stage 1: grown bounds and delta per axis.
  logic signed [NUM_W-1:0]   s1_s_q  [NUM_AXES];
  logic signed [NUM_W-1:0]   s1_lo_q [NUM_AXES];
  logic signed [NUM_W-1:0]   s1_hi_q [NUM_AXES];
  logic signed [DEL_W-1:0]   s1_d_q  [NUM_AXES];

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        s1_s_q[a]  <= NUM_W'($signed(s_axis_tdata_i[COORD_W*a +: COORD_W]));
        s1_lo_q[a] <= NUM_W'($signed(s_axis_tdata_i[COORD_W*(6+a) +: COORD_W]))
                      - NUM_W'(ext_q[a]) - NUM_W'(eps_q);
        s1_hi_q[a] <= NUM_W'($signed(s_axis_tdata_i[COORD_W*(9+a) +: COORD_W]))
                      + NUM_W'(ext_q[a]) + NUM_W'(eps_q);
        s1_d_q[a]  <= DEL_W'($signed(s_axis_tdata_i[COORD_W*(3+a) +: COORD_W]))
                      - DEL_W'($signed(s_axis_tdata_i[COORD_W*a +: COORD_W]));
      end
    end
  end

  // Stage 2: slab numerators, oriented so that the delta is positive.
  slab_num_t        s2_n1_q   [NUM_AXES];
  slab_num_t        s2_n2_q   [NUM_AXES];
  logic [DEL_W-1:0] s2_dabs_q [NUM_AXES];
  logic             s2_par_q  [NUM_AXES];
  logic             s2_in_q   [NUM_AXES];

  always_ff @(posedge clk_i) begin
    if (stage_en[1]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (s1_d_q[a][DEL_W-1]) begin
          s2_n1_q[a]   <= s1_s_q[a] - s1_lo_q[a];
          s2_n2_q[a]   <= s1_s_q[a] - s1_hi_q[a];
          s2_dabs_q[a] <= DEL_W'(~s1_d_q[a]) + DEL_W'(1);
        end else begin
          s2_n1_q[a]   <= s1_lo_q[a] - s1_s_q[a];
          s2_n2_q[a]   <= s1_hi_q[a] - s1_s_q[a];
          s2_dabs_q[a] <= DEL_W'(s1_d_q[a]);
        end
        s2_par_q[a] <= (s1_d_q[a] == '0);
        s2_in_q[a]  <= (s1_s_q[a] >= s1_lo_q[a]) && (s1_s_q[a] <= s1_hi_q[a]);
      end
    end
  end

  // Stage 3: entry and exit numerators.
  slab_num_t        s3_en_q   [NUM_AXES];
  slab_num_t        s3_ex_q   [NUM_AXES];
  logic [DEL_W-1:0] s3_dabs_q [NUM_AXES];
  logic             s3_par_q  [NUM_AXES];
  logic             s3_in_q   [NUM_AXES];

  always_ff @(posedge clk_i) begin
    if (stage_en[2]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (s2_n1_q[a] < s2_n2_q[a]) begin
          s3_en_q[a] <= s2_n1_q[a];
          s3_ex_q[a] <= s2_n2_q[a];
        end else begin
          s3_en_q[a] <= s2_n2_q[a];
          s3_ex_q[a] <= s2_n1_q[a];
        end
        s3_dabs_q[a] <= s2_dabs_q[a];
        s3_par_q[a]  <= s2_par_q[a];
        s3_in_q[a]   <= s2_in_q[a];
      end
    end
  end

  // Stage 4: magnitudes, signs and the checks against 0 and 1 per axis.
  slab_mag_t        s4_en_mag_q [NUM_AXES];
  slab_mag_t        s4_ex_mag_q [NUM_AXES];
  logic             s4_en_pos_q [NUM_AXES];
  logic             s4_ex_neg_q [NUM_AXES];
  logic [DEL_W-1:0] s4_dabs_q   [NUM_AXES];
  logic             s4_par_q    [NUM_AXES];
  logic             s4_ok_q     [NUM_AXES];

  always_ff @(posedge clk_i) begin
    if (stage_en[3]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        s4_en_mag_q[a] <= s3_en_q[a][NUM_W-1] ? MAG_W'(-s3_en_q[a]) : MAG_W'(s3_en_q[a]);
        s4_ex_mag_q[a] <= s3_ex_q[a][NUM_W-1] ? MAG_W'(-s3_ex_q[a]) : MAG_W'(s3_ex_q[a]);
        s4_en_pos_q[a] <= !s3_en_q[a][NUM_W-1] && (s3_en_q[a] != '0);
        s4_ex_neg_q[a] <= s3_ex_q[a][NUM_W-1];
        s4_dabs_q[a]   <= s3_dabs_q[a];
        s4_par_q[a]    <= s3_par_q[a];
        // A moving axis must enter by t = 1 and leave no earlier than t = 0.
        s4_ok_q[a]     <= s3_par_q[a] ? s3_in_q[a] :
                          ((s3_en_q[a] <= $signed(NUM_W'(s3_dabs_q[a])))
                           && !s3_ex_q[a][NUM_W-1]);
      end
    end
  end

  // Stage 5: partial products for entry_i * d_j against exit_j * d_i.
  logic [63:0] s5_p_lo_q  [NUM_PAIRS];
  logic [63:0] s5_q_lo_q  [NUM_PAIRS];
  logic [32:0] s5_p_mid_q [NUM_PAIRS];
  logic [32:0] s5_q_mid_q [NUM_PAIRS];
  logic        s5_p_top_q [NUM_PAIRS];
  logic        s5_q_top_q [NUM_PAIRS];
  logic        s5_skip_q  [NUM_PAIRS];
  logic        s5_en_pos_q[NUM_PAIRS];
  logic        s5_ex_neg_q[NUM_PAIRS];
  logic        s5_all_ok_q;

  for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_pair
    localparam int unsigned PI = p / 2;
    localparam int unsigned PJ = (PI + 1 + p % 2) % NUM_AXES;

    always_ff @(posedge clk_i) begin
      if (stage_en[4]) begin
        s5_p_lo_q[p]  <= 64'(s4_en_mag_q[PI][31:0]) * 64'(s4_dabs_q[PJ][31:0]);
        s5_q_lo_q[p]  <= 64'(s4_ex_mag_q[PJ][31:0]) * 64'(s4_dabs_q[PI][31:0]);
        s5_p_mid_q[p] <= (s4_en_mag_q[PI][32] ? 33'(s4_dabs_q[PJ][31:0]) : 33'd0)
                       + (s4_dabs_q[PJ][32]   ? 33'(s4_en_mag_q[PI][31:0]) : 33'd0);
        s5_q_mid_q[p] <= (s4_ex_mag_q[PJ][32] ? 33'(s4_dabs_q[PI][31:0]) : 33'd0)
                       + (s4_dabs_q[PI][32]   ? 33'(s4_ex_mag_q[PJ][31:0]) : 33'd0);
        s5_p_top_q[p] <= s4_en_mag_q[PI][32] & s4_dabs_q[PJ][32];
        s5_q_top_q[p] <= s4_ex_mag_q[PJ][32] & s4_dabs_q[PI][32];
        s5_skip_q[p]  <= s4_par_q[PI] | s4_par_q[PJ];
        s5_en_pos_q[p] <= s4_en_pos_q[PI];
        s5_ex_neg_q[p] <= s4_ex_neg_q[PJ];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[4]) begin
      s5_all_ok_q <= s4_ok_q[0] & s4_ok_q[1] & s4_ok_q[2];
    end
  end

  // Stage 6: final sums and compares. Entry of each axis must not lie past
  // the exit of any other axis.
  logic [PROD_W-1:0]    p_full [NUM_PAIRS];
  logic [PROD_W-1:0]    q_full [NUM_PAIRS];
  logic [NUM_PAIRS-1:0] pair_ok;
  logic                 hit_d;
  logic                 hit_q;

  always_comb begin
    for (int p = 0; p < NUM_PAIRS; p++) begin
      p_full[p] = PROD_W'({s5_p_top_q[p], 64'd0}) + PROD_W'({s5_p_mid_q[p], 32'd0})
                + PROD_W'(s5_p_lo_q[p]);
      q_full[p] = PROD_W'({s5_q_top_q[p], 64'd0}) + PROD_W'({s5_q_mid_q[p], 32'd0})
                + PROD_W'(s5_q_lo_q[p]);
      priority if (s5_skip_q[p]) begin
        pair_ok[p] = 1'b1;
      end else if (!s5_en_pos_q[p] && !s5_ex_neg_q[p]) begin
        pair_ok[p] = 1'b1;
      end else if (s5_en_pos_q[p] && s5_ex_neg_q[p]) begin
        pair_ok[p] = 1'b0;
      end else if (s5_en_pos_q[p]) begin
        pair_ok[p] = (p_full[p] <= q_full[p]);
      end else begin
        // Entry not positive, exit negative: compare magnitudes the other way round.
        pair_ok[p] = (p_full[p] >= q_full[p]);
      end
    end
    hit_d = s5_all_ok_q & (&pair_ok);
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[5]) begin
      hit_q <= hit_d;
    end
  end

  assign m_axis_tvalid_o = valid_q[NUM_STAGES-1];
  assign m_axis_tdata_o  = {{(AXIS_OUT_W-1){1'b0}}, hit_q};

endmodule

@@ dv/swept_box_segment_hit_test_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Swept box segment hit test testbench
// Streams segment and box queries through the hit test under several
// register settings, predicts each hit flag with exact rational slab
// compares, and checks every result beat in order. Both stream sides idle
// at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module swept_box_segment_hit_test_tb;
  import sbsh_pkg::*;

  typedef logic [NUM_AXES-1:0][COORD_W-1:0] vec3_t;

  // Field order matches tdata: segment start in the lowest bits.
  typedef struct packed {
    vec3_t box_max;
    vec3_t box_min;
    vec3_t seg_end;
    vec3_t seg_start;
  } seg_query_t;

  localparam logic [COORD_W-1:0]   C_MIN              = 32'h8000_0000;
  localparam logic [COORD_W-1:0]   C_MAX              = 32'h7FFF_FFFF;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_UNMAPPED = 8'd200;
  localparam int unsigned          STALL_LIMIT        = 4000;
  localparam int unsigned          LONG_HOLD          = 300;
  localparam int unsigned          HOLD_AT            = 500;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic [AXIS_IN_W-1:0]  s_tdata   = '0;
  logic                  s_valid   = 1'b0;
  logic                  s_tready;
  logic [AXIS_OUT_W-1:0] m_tdata;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Register copies used for prediction.
  logic [EXT_W-1:0] cfg_extent [NUM_AXES];
  logic [EPS_W-1:0] cfg_eps;

  seg_query_t  pending_queries [$];
  bit          expected_hits [$];
  bit          hit_expected;
  bit          in_taken         = 1'b0;
  bit          idle_on          = 1'b0;
  bit          long_hold_done   = 1'b0;
  int unsigned in_gap           = 0;
  int unsigned out_gap          = 0;
  int unsigned accepted_queries = 0;
  int unsigned quiet_cycles     = 0;
  int unsigned fail_count       = 0;

  swept_box_segment_hit_test dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Sign of a/b - c/e for positive b and e, exact at 128 bits.
  function automatic int frac_order(longint a, longint b, longint c, longint e);
    logic signed [127:0] lhs;
    logic signed [127:0] rhs;
    lhs = a * e;
    rhs = c * b;
    return (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
  endfunction

  function automatic bit predict_hit(seg_query_t q);
    longint s, e, lo, hi, d, n1, n2, t_in, t_out;
    longint tmin_n, tmin_d, tmax_n, tmax_d;
    bit     hit;
    tmin_n = 0;
    tmin_d = 1;
    tmax_n = 1;
    tmax_d = 1;
    hit    = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      s  = longint'($signed(q.seg_start[a]));
      e  = longint'($signed(q.seg_end[a]));
      lo = longint'($signed(q.box_min[a])) - longint'(cfg_extent[a]) - longint'(cfg_eps);
      hi = longint'($signed(q.box_max[a])) + longint'(cfg_extent[a]) + longint'(cfg_eps);
      d  = e - s;
      if (d == 0) begin
        if (s < lo || s > hi) hit = 1'b0;
      end else begin
        n1 = lo - s;
        n2 = hi - s;
        if (d < 0) begin
          n1 = -n1;
          n2 = -n2;
          d  = -d;
        end
        t_in  = (n1 < n2) ? n1 : n2;
        t_out = (n1 < n2) ? n2 : n1;
        if (frac_order(t_in, d, tmin_n, tmin_d) > 0) begin
          tmin_n = t_in;
          tmin_d = d;
        end
        if (frac_order(t_out, d, tmax_n, tmax_d) < 0) begin
          tmax_n = t_out;
          tmax_d = d;
        end
      end
    end
    if (frac_order(tmin_n, tmin_d, tmax_n, tmax_d) > 0) hit = 1'b0;
    return hit;
  endfunction

  function automatic vec3_t v3(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                               logic [COORD_W-1:0] z);
    return {z, y, x};
  endfunction

  function automatic seg_query_t build(vec3_t s, vec3_t e, vec3_t bmin, vec3_t bmax);
    seg_query_t q;
    q.seg_start = s;
    q.seg_end   = e;
    q.box_min   = bmin;
    q.box_max   = bmax;
    return q;
  endfunction

  // A coordinate within a few half-sizes of the center; h stays below 2^28.
  function automatic logic [COORD_W-1:0] near(logic [COORD_W-1:0] c, logic [COORD_W-1:0] h);
    return c + ($urandom % (6 * h + 257)) - (3 * h + 128);
  endfunction

  function automatic seg_query_t random_query();
    seg_query_t        q;
    int unsigned       kind;
    logic [1:0]        sel;
    logic [COORD_W-1:0] c, h, lo_edge, hi_edge, t;
    kind = $urandom_range(0, 9);
    for (int a = 0; a < NUM_AXES; a++) begin
      if (kind >= 8) begin
        q.seg_start[a] = $urandom;
        q.seg_end[a]   = $urandom;
        q.box_min[a]   = $urandom;
        q.box_max[a]   = $urandom;
      end else begin
        c = $signed($urandom) >>> $urandom_range(1, 31);
        h = $urandom >> $urandom_range(4, 31);
        q.box_min[a]   = c - h;
        q.box_max[a]   = c + h;
        q.seg_start[a] = near(c, h);
        q.seg_end[a]   = ($urandom_range(0, 5) == 0) ? q.seg_start[a] : near(c, h);
        if ($urandom_range(0, 15) == 0) begin
          q.box_min[a] = c + h;
          q.box_max[a] = c - h;
        end
      end
    end
    // Put one segment end right on, or one step off, a grown slab edge.
    if (kind == 6 || kind == 7) begin
      sel     = 2'($urandom_range(0, NUM_AXES - 1));
      lo_edge = q.box_min[sel] - cfg_extent[sel] - cfg_eps;
      hi_edge = q.box_max[sel] + cfg_extent[sel] + cfg_eps;
      t = ($urandom_range(0, 1) ? lo_edge : hi_edge) + $urandom_range(0, 2) - 1;
      if ($urandom_range(0, 1)) q.seg_start[sel] = t;
      else q.seg_end[sel] = t;
    end
    return q;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_index,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= reg_index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    unique case (reg_index)
      REG_EXTENT_X:     cfg_extent[0] = value[EXT_W-1:0];
      REG_EXTENT_Y:     cfg_extent[1] = value[EXT_W-1:0];
      REG_EXTENT_Z:     cfg_extent[2] = value[EXT_W-1:0];
      REG_SLAB_EPSILON: cfg_eps       = value[EPS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_config(input logic [CFG_DATA_W-1:0] ext_x,
                             input logic [CFG_DATA_W-1:0] ext_y,
                             input logic [CFG_DATA_W-1:0] ext_z,
                             input logic [CFG_DATA_W-1:0] eps);
    write_reg(REG_EXTENT_X, ext_x);
    write_reg(REG_EXTENT_Y, ext_y);
    write_reg(REG_EXTENT_Z, ext_z);
    write_reg(REG_SLAB_EPSILON, eps);
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_queries.size() != 0 || s_valid || expected_hits.size() != 0)
      @(negedge clk);
    repeat (NUM_STAGES + 2) @(posedge clk);
  endtask

  task automatic push_random(input int unsigned count);
    repeat (count) pending_queries.push_back(random_query());
  endtask

  task automatic push_directed();
    vec3_t unit_box_min, unit_box_max, all_min, all_max;
    unit_box_min = v3(0, 0, 0);
    unit_box_max = v3(1024, 1024, 1024);
    all_min      = v3(C_MIN, C_MIN, C_MIN);
    all_max      = v3(C_MAX, C_MAX, C_MAX);
    // Crossing and missing segments.
    pending_queries.push_back(build(v3(-512, 512, 512), v3(1536, 512, 512),
                                    unit_box_min, unit_box_max));
    pending_queries.push_back(build(v3(-512, -512, 2048), v3(1536, 1536, 4096),
                                    unit_box_min, unit_box_max));
    // Parallel axis inside, on the grown edge and one step outside.
    pending_queries.push_back(build(v3(512, 512, -512), v3(512, 512, 1536),
                                    unit_box_min, unit_box_max));
    pending_queries.push_back(build(v3(1032, 512, -512), v3(1032, 512, 1536),
                                    unit_box_min, unit_box_max));
    pending_queries.push_back(build(v3(1033, 512, -512), v3(1033, 512, 1536),
                                    unit_box_min, unit_box_max));
    // Degenerate segments.
    pending_queries.push_back(build(v3(10, 20, 30), v3(10, 20, 30),
                                    unit_box_min, unit_box_max));
    pending_queries.push_back(build(v3(-9, 0, 0), v3(-9, 0, 0),
                                    unit_box_min, unit_box_max));
    pending_queries.push_back(build(v3(-8, 0, 0), v3(-8, 0, 0),
                                    unit_box_min, unit_box_max));
    // Inverted box on x, with a parallel and a crossing segment.
    pending_queries.push_back(build(v3(512, 512, -512), v3(512, 512, 1536),
                                    v3(1024, 0, 0), v3(0, 1024, 1024)));
    pending_queries.push_back(build(v3(-512, 512, 512), v3(1536, 600, 700),
                                    v3(1024, 0, 0), v3(0, 1024, 1024)));
    // Segment end touching the grown face, then one step short of it.
    pending_queries.push_back(build(v3(-1000, 512, 512), v3(-8, 512, 512),
                                    unit_box_min, unit_box_max));
    pending_queries.push_back(build(v3(-1000, 512, 512), v3(-9, 512, 512),
                                    unit_box_min, unit_box_max));
    // Box behind the start, and a reversed segment through the box.
    pending_queries.push_back(build(v3(2000, 512, 512), v3(3000, 512, 512),
                                    unit_box_min, unit_box_max));
    pending_queries.push_back(build(v3(3000, 512, 512), v3(-1000, 512, 512),
                                    unit_box_min, unit_box_max));
    // Extreme coordinates.
    pending_queries.push_back(build(all_min, all_max, all_min, all_max));
    pending_queries.push_back(build(all_min, all_max, all_max, all_min));
    pending_queries.push_back(build(all_max, all_max, all_max, all_max));
    pending_queries.push_back(build(all_max, all_min, unit_box_min, unit_box_max));
  endtask

  initial begin
    cfg_extent[0] = '0;
    cfg_extent[1] = '0;
    cfg_extent[2] = '0;
    cfg_eps       = EPS_RESET;
    wait (rst_n);

    // Reset register values.
    idle_on <= 1'b1;
    push_directed();
    drain();

    // Largest extents and margin.
    load_config(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'h00_00FF);
    push_directed();
    push_random(150);
    drain();

    // No growth at all; upper data bits of the margin write are dropped, and a
    // write to an unmapped index must change nothing.
    idle_on <= 1'b0;
    load_config(24'h0, 24'h0, 24'h0, 24'hFF_FF00);
    write_reg(CFG_INDEX_UNMAPPED, 24'h12_3456);
    push_random(250);
    drain();

    // Mixed extents; the long result hold falls inside this phase.
    idle_on <= 1'b1;
    load_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(0, 4095)),
                CFG_DATA_W'($urandom_range(0, 255)), CFG_DATA_W'($urandom_range(0, 255)));
    push_random(300);
    drain();

    // Closing phase runs without idling on either side.
    idle_on <= 1'b0;
    load_config(CFG_DATA_W'($urandom_range(0, 1023)), CFG_DATA_W'($urandom_range(0, 1023)),
                CFG_DATA_W'($urandom_range(0, 1023)), CFG_DATA_W'($urandom_range(0, 255)));
    push_random(400);
    drain();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Input driver.
  always @(negedge clk) begin
    if (!rst_n) begin
      s_valid <= 1'b0;
      in_gap  <= 0;
    end else if (!s_valid || in_taken) begin
      if (in_gap != 0) begin
        in_gap  <= in_gap - 1;
        s_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        in_gap  <= $urandom_range(0, 16);
        s_valid <= 1'b0;
      end else if (pending_queries.size() != 0) begin
        s_tdata <= pending_queries.pop_front();
        s_valid <= 1'b1;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Result side ready, with one long hold so the pipeline fills and backs up.
  always @(negedge clk) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
      out_gap  <= 0;
    end else if (!long_hold_done && accepted_queries >= HOLD_AT) begin
      long_hold_done <= 1'b1;
      out_gap        <= LONG_HOLD;
      m_tready       <= 1'b0;
    end else if (out_gap != 0) begin
      out_gap  <= out_gap - 1;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      out_gap  <= $urandom_range(0, 16);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: results are checked before the new expectation is queued.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_valid && s_tready;
      if (m_tvalid && m_tready) begin
        if (expected_hits.size() == 0) begin
          $error("hit: no result expected, actual %0b", m_tdata[0]);
          fail_count++;
        end else begin
          hit_expected = expected_hits.pop_front();
          if (m_tdata[0] !== hit_expected) begin
            $error("hit: expected %0b, actual %0b", hit_expected, m_tdata[0]);
            fail_count++;
          end
        end
      end
      if (s_valid && s_tready) begin
        expected_hits.push_back(predict_hit(s_tdata));
        accepted_queries <= accepted_queries + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_valid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
